[hw/rtl/dxt3_block_decoder_macros.svh]
// assertion macros for the dxt3 block decoder
`ifndef DXT3_BLOCK_DECODER_MACROS_SVH
`define DXT3_BLOCK_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define DXT3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dxt3 block decoder check failed");

// condition that must never be true outside reset
`define DXT3_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("dxt3 block decoder forbidden condition");

`else

`define DXT3_ASSERT(lbl, prop)
`define DXT3_ASSERT_NEVER(lbl, cond)

`endif

`endif

[hw/rtl/dxt3_pkg.sv]
// types, constants and palette helpers shared by the dxt3 block decoder
`default_nettype none

package dxt3_pkg;

  localparam int unsigned InWidth  = 128;
  localparam int unsigned OutWidth = 40;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  localparam logic [3:0] LastPix = 4'hF;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // one decoded block waiting for the back end
  typedef struct packed {
    logic [63:0]    alpha_bits;
    logic [31:0]    index_bits;
    rgb_t [3:0]     palette;
  } blk_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } qstat_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic rgb_t expand565(input logic [15:0] c);
    rgb_t e;
    e.r = widen5(c[15:11]);
    e.g = widen6(c[10:5]);
    e.b = widen5(c[4:0]);
    return e;
  endfunction

  // floor(x / 3) for x up to 765, by reciprocal multiply (683 / 2048)
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = {11'd0, x} * 21'd683;
    return p[18:11];
  endfunction

  // (2a + b) / 3 per channel
  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b);
    logic [9:0] s;
    s = {1'b0, a, 1'b0} + {2'b00, b};
    return div3(s);
  endfunction

  function automatic rgb_t mix(input rgb_t a, input rgb_t b);
    rgb_t m;
    m.r = blend(a.r, b.r);
    m.g = blend(a.g, b.g);
    m.b = blend(a.b, b.b);
    return m;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dxt3_front.sv]
// front end: accepts a block, builds its four-entry palette, pushes it to the queue
`default_nettype none

module dxt3_front
  import dxt3_pkg::*;
(
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [InWidth-1:0]  s_axis_tdata_i,
  input  wire logic                full_i,
  output logic                     push_o,
  output blk_t                     blk_o
);

  logic [63:0] alpha_bits;
  logic [15:0] endpoint_zero;
  logic [15:0] endpoint_one;
  logic [31:0] index_bits;
  rgb_t        ep0;
  rgb_t        ep1;

  assign alpha_bits    = s_axis_tdata_i[63:0];
  assign endpoint_zero = s_axis_tdata_i[79:64];
  assign endpoint_one  = s_axis_tdata_i[95:80];
  assign index_bits    = s_axis_tdata_i[127:96];

  always_comb begin
    ep0 = expand565(endpoint_zero);
    ep1 = expand565(endpoint_one);
    blk_o.alpha_bits = alpha_bits;
    blk_o.index_bits = index_bits;
    blk_o.palette[0] = ep0;
    blk_o.palette[1] = ep1;
    blk_o.palette[2] = mix(ep0, ep1);
    blk_o.palette[3] = mix(ep1, ep0);
  end

  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i;

endmodule

`default_nettype wire

[hw/rtl/dxt3_queue.sv]
// two-entry queue of decoded blocks between front and back end
`default_nettype none

module dxt3_queue
  import dxt3_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire blk_t blk_i,
  input  wire logic pop_i,
  output blk_t      head_o,
  output qstat_t    stat_o
);

  blk_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= blk_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.full  = (count_q == QCntW'(QDepth));
  assign stat_o.empty = (count_q == '0);

endmodule

`default_nettype wire

[hw/rtl/dxt3_back.sv]
// back end: walks the head block pixel by pixel into the output register
`default_nettype none

module dxt3_back
  import dxt3_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire blk_t                 head_i,
  input  wire logic                 head_valid_i,
  output logic                      pop_o,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [OutWidth-1:0]       m_axis_tdata_o,
  output logic                      m_axis_tlast_o
);

  logic [3:0]          pix_q, pix_d;
  logic                vld_q, vld_d;
  logic [OutWidth-1:0] data_q, data_d;
  logic                last_q, last_d;
  logic                load;
  logic [3:0]          nib;
  logic [1:0]          sel;
  logic [7:0]          alpha;
  rgb_t                col;

  always_comb begin
    load  = head_valid_i && (!vld_q || m_axis_tready_i);
    nib   = head_i.alpha_bits[{pix_q, 2'b00} +: 4];
    sel   = head_i.index_bits[{pix_q, 1'b0} +: 2];
    // nibble * 17 * 2 saturates once the top bit is set
    alpha = nib[3] ? 8'hFF : {nib[2:0], nib, 1'b0};
    col   = head_i.palette[sel];
    pop_o = load && (pix_q == LastPix);
    pix_d = load ? pix_q + 1'b1 : pix_q;
    vld_d = load || (vld_q && !m_axis_tready_i);
    data_d = load ? {4'b0000, col.b, col.g, col.r, alpha, pix_q[1:0], pix_q[3:2]} : data_q;
    last_d = load ? (pix_q == LastPix) : last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
      vld_q <= 1'b0;
    end else begin
      pix_q <= pix_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

endmodule

`default_nettype wire

[hw/rtl/dxt3_block_decoder.sv]
// top level of the dxt3 (bc2) texture block decoder
`default_nettype none

// decodes one 16-byte dxt3 block per input item into sixteen argb pixels in
// raster order, one pixel item per clock while the output side takes them and
// the queue holds a block, so blocks follow each other with no gap. the pixel
// counter and output register in the back end set that rate.
// the front end expands the rgb565 endpoints, derives the two blended palette
// entries (always four-color mode) and pushes the block into a two-deep queue
// in the same cycle it is accepted; the block being walked keeps its slot until
// its last pixel, so one more block can be taken while the back end is busy.
// after acceptance the first pixel passes a queue slot, then the output register.
// alpha is the pixel's nibble replicated to 8 bits, doubled, clipped at 255.

`include "dxt3_block_decoder_macros.svh"

module dxt3_block_decoder
  import dxt3_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // alpha_bits[63:0], endpoint_zero[79:64], endpoint_one[95:80], index_bits[127:96]
  input  wire logic [InWidth-1:0]  s_axis_tdata_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // pixel_row[1:0], pixel_col[3:2], alpha_out[11:4], red_out[19:12],
  // green_out[27:20], blue_out[35:28], zero fill[39:36]
  output logic [OutWidth-1:0]      m_axis_tdata_o,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // last_pixel: high on the sixteenth pixel of a block
  output logic                     m_axis_tlast_o
);

  // front to queue
  logic   push;
  blk_t   front_blk;
  // queue to back
  blk_t   head;
  logic   pop;
  qstat_t qstat;

  dxt3_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .full_i          (qstat.full),
    .push_o          (push),
    .blk_o           (front_blk)
  );

  dxt3_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .blk_i  (front_blk),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  // back end only reads the head while the queue holds a block
  dxt3_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_valid_i    (!qstat.empty),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // accepted block must always find a free queue slot
  `DXT3_ASSERT(a_push_has_room, (s_axis_tvalid_i && s_axis_tready_o) |-> (qstat.count < QCntW'(QDepth)))

  // never pop an empty queue
  `DXT3_ASSERT_NEVER(a_no_pop_empty, pop && qstat.empty)

  // the pixel flagged last is always at row 3, column 3
  `DXT3_ASSERT(a_last_is_corner, (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o[3:0] == 4'hF))

  // popping the last pixel of a block presents a last item next cycle
  `DXT3_ASSERT(a_pop_gives_last, pop |=> (m_axis_tvalid_o && m_axis_tlast_o))

endmodule

`default_nettype wire
